// ===== design/b64d_pkg.sv =====
// Shared types, constants and decode functions for the Base64 stream decoder.
package b64d_pkg;

    // Character codes that matter to the decoder.
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    // Sextet offsets of the lower-case letters and the digits, and the values of '+' and '/'.
    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_VALUE = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    // Default depth of the job queue between front and back end.
    localparam int JOB_QUEUE_DEPTH = 4;

    // Bytes of one decoded group.
    typedef logic [2:0][7:0] group_bytes_t;

    // One decode job: up to three bytes, how many are valid, and the stream end flag.
    typedef struct packed {
        group_bytes_t bytes;
        logic [1:0]   count;
        logic         last;
    } job_t;

    // Six-bit value of one character; characters outside the alphabet give zero.
    function automatic logic [5:0] sextet(input logic [7:0] ch);
        logic [5:0] value;
        value = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            value = 6'(ch - CHAR_UPPER_A);
        end
        else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            value = 6'(ch - CHAR_LOWER_A) + LOWER_BASE;
        end
        else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
        begin
            value = 6'(ch - CHAR_DIGIT_0) + DIGIT_BASE;
        end
        else if (ch == CHAR_PLUS)
        begin
            value = PLUS_VALUE;
        end
        else if (ch == CHAR_SLASH)
        begin
            value = SLASH_VALUE;
        end
        return value;
    endfunction

    // Decode a group of four characters into bytes and a byte count of 1 to 3.
    function automatic job_t decode_group(input logic [7:0] w, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] z);
        job_t       job;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [5:0] d;
        a = sextet(w);
        b = sextet(x);
        c = sextet(y);
        d = sextet(z);
        job.bytes    = '0;
        job.last     = 1'b0;
        job.bytes[0] = {a, b[5:4]};
        if (y == CHAR_PAD)
        begin
            job.count = 2'd1;
        end
        else if (z == CHAR_PAD)
        begin
            job.bytes[1] = {b[3:0], c[5:2]};
            job.count    = 2'd2;
        end
        else
        begin
            job.bytes[1] = {b[3:0], c[5:2]};
            job.bytes[2] = {c[1:0], d};
            job.count    = 2'd3;
        end
        return job;
    endfunction

endpackage

// ===== design/base64_stream_decoder_unit.sv =====
// Top level of the Base64 stream decoder: front end, job queue and back end.
//
// The decoder takes one Base64 character per transaction and can accept one in every
// clock cycle while full is low. Each group of four characters, or a partial group of two
// or three characters flushed by a character marked is_last, becomes one job of one to
// three bytes in a queue of QUEUE_DEPTH jobs; the back end sends those bytes one per cycle,
// while results are taken, through an output register. A job is written into the queue
// before the back end moves its first byte into that register. full is high while the
// job queue is full, which only happens when results are not being taken.
// '=' counts as padding only by its place in a group, other characters outside the
// alphabet decode as zero, and byte_count gives the running byte total modulo 2^32.
module base64_stream_decoder_unit
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  symbol,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_byte,
    output logic        last_of_run,
    output logic        end_of_stream,
    output logic [31:0] byte_count
);

    logic job_valid;
    job_t front_job;
    job_t head_job;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    assign full = queue_full;

    // Character intake and group decode.
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .symbol     (symbol),
        .is_last    (is_last),
        .queue_full (queue_full),
        .job_valid  (job_valid),
        .job        (front_job)
    );

    // Decoupling queue of decoded jobs.
    b64d_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (front_job),
        .full   (queue_full),
        .rd_en  (queue_pop),
        .rd_job (head_job),
        .empty  (queue_empty)
    );

    // Byte serializer and output register.
    b64d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .job_empty     (queue_empty),
        .job_pop       (queue_pop),
        .pop           (pop),
        .empty         (empty),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream),
        .byte_count    (byte_count)
    );

endmodule

// ===== design/b64d_front.sv =====
// Front end: accepts characters, holds a partial group and forms decode jobs.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] symbol,
    input  logic       is_last,
    input  logic       queue_full,
    output logic       job_valid,
    output job_t       job
);

    logic [1:0]      pend_count_reg;
    logic [1:0]      pend_count_next;
    logic [2:0][7:0] pend_chars_reg;
    logic            accept;
    logic            group_done;
    logic [7:0]      char_w;
    logic [7:0]      char_x;
    logic [7:0]      char_y;
    logic [7:0]      char_z;
    job_t            decoded;

    assign accept = push && !queue_full;

    // Pick the four characters of a completed or flushed group.
    always_comb
    begin
        group_done = 1'b0;
        char_w     = pend_chars_reg[0];
        char_x     = pend_chars_reg[1];
        char_y     = CHAR_PAD;
        char_z     = CHAR_PAD;
        if (pend_count_reg == 2'd3)
        begin
            group_done = 1'b1;
            char_y     = pend_chars_reg[2];
            char_z     = symbol;
        end
        else if (is_last && pend_count_reg == 2'd1)
        begin
            group_done = 1'b1;
            char_x     = symbol;
        end
        else if (is_last && pend_count_reg == 2'd2)
        begin
            group_done = 1'b1;
            char_y     = symbol;
        end
    end

    // Decode the group and tag it with the stream end flag.
    always_comb
    begin
        decoded      = decode_group(char_w, char_x, char_y, char_z);
        decoded.last = is_last;
        job          = decoded;
        job_valid    = accept && group_done;
    end

    // Held character count: cleared after a full group or at the end of the stream.
    always_comb
    begin
        pend_count_next = pend_count_reg;
        if (accept)
        begin
            if (pend_count_reg == 2'd3 || is_last)
            begin
                pend_count_next = '0;
            end
            else
            begin
                pend_count_next = pend_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_count_reg <= '0;
        end
        else
        begin
            pend_count_reg <= pend_count_next;
        end
    end

    // Held characters need no reset; each is written before it is read.
    always_ff @(posedge clk)
    begin
        if (accept && pend_count_reg != 2'd3)
        begin
            pend_chars_reg[pend_count_reg] <= symbol;
        end
    end

endmodule

// ===== design/b64d_job_queue.sv =====
// Short queue of decode jobs between the front end and the back end.
module b64d_job_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slots_reg[rd_ptr_reg];

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== design/b64d_back.sv =====
// Back end: streams each job's bytes out one per cycle while results are taken, with a running total.
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_empty,
    output logic        job_pop,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  data_byte,
    output logic        last_of_run,
    output logic        end_of_stream,
    output logic [31:0] byte_count
);

    logic [1:0]  index_reg;
    logic        out_valid_reg;
    logic [7:0]  data_reg;
    logic        run_end_reg;
    logic        stream_end_reg;
    logic [31:0] total_reg;
    logic        advance;
    logic        final_byte;

    // A new byte moves into the output register when a job is waiting and the register is free or being taken.
    assign advance    = !job_empty && (!out_valid_reg || pop);
    assign final_byte = (index_reg == job.count - 2'd1);
    assign job_pop    = advance && final_byte;

    // Control state: byte index, output valid and running total.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_reg + 32'd1;
                index_reg     <= final_byte ? 2'd0 : index_reg + 2'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg       <= job.bytes[index_reg];
            run_end_reg    <= final_byte;
            stream_end_reg <= final_byte && job.last;
        end
    end

    assign empty         = !out_valid_reg;
    assign data_byte     = data_reg;
    assign last_of_run   = run_end_reg;
    assign end_of_stream = stream_end_reg;
    assign byte_count    = total_reg;

endmodule

// ===== design/b64d_checker.sv =====
// Port-level checks on the Base64 stream decoder, bound to its top level.
module b64d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  data_byte,
    input logic        last_of_run,
    input logic        end_of_stream,
    input logic [31:0] byte_count
);

    logic        seen_reg;
    logic [31:0] prev_count_reg;
    logic        out_take;

    assign out_take = pop && !empty;

    // Remember the byte total of the previous output transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_count_reg <= '0;
        end
        else if (out_take)
        begin
            seen_reg       <= 1'b1;
            prev_count_reg <= byte_count;
        end
    end

    // During reset no result is shown and input is not refused.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("outputs not idle during reset");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(byte_count)))
        else $error("waiting result changed before it was taken");

    // Consecutive output transactions count up by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && seen_reg) |-> (byte_count == prev_count_reg + 32'd1))
        else $error("byte total did not step by one");

    // The final byte of the stream also ends its run.
    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!end_of_stream || last_of_run))
        else $error("end of stream without end of run");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .data_byte     (data_byte),
    .last_of_run   (last_of_run),
    .end_of_stream (end_of_stream),
    .byte_count    (byte_count)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Base64 stream decoder unit.
`timescale 1ns / 100ps

module tb_top;
    import b64d_pkg::*;

    // One decoded byte as it should appear on the result ports.
    typedef struct {
        logic [7:0]  data;
        logic        run_end;
        logic        stream_end;
        logic [31:0] total;
    } decoded_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic [7:0]  symbol;
    logic        is_last;
    logic        pop;
    wire         full;
    wire         empty;
    wire  [7:0]  data_byte;
    wire         last_of_run;
    wire         end_of_stream;
    wire  [31:0] byte_count;

    // Decoder state as predicted by the testbench.
    logic [1:0]  held_count;
    logic [7:0]  held_chars [3];
    logic [31:0] bytes_emitted;

    decoded_byte_t pending_bytes [$];

    int  errors        = 0;
    int  chars_sent    = 0;
    int  bytes_checked = 0;
    int  full_cycles   = 0;
    int  streams_ended = 0;
    int  rx_hold_req   = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;

    base64_stream_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .symbol        (symbol),
        .is_last       (is_last),
        .empty         (empty),
        .pop           (pop),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .end_of_stream (end_of_stream),
        .byte_count    (byte_count)
    );

    // Free-running clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Six-bit value of a character; anything outside the alphabet counts as zero.
    function automatic logic [5:0] char_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
        begin
            return 6'(ch - 8'h41);
        end
        if (ch >= "a" && ch <= "z")
        begin
            return 6'(ch - 8'h61 + 8'd26);
        end
        if (ch >= "0" && ch <= "9")
        begin
            return 6'(ch - 8'h30 + 8'd52);
        end
        if (ch == "+")
        begin
            return 6'd62;
        end
        if (ch == "/")
        begin
            return 6'd63;
        end
        return 6'd0;
    endfunction

    // Expands four characters into bytes and returns how many of them are valid.
    function automatic int expand_quad(input logic [7:0] w, input logic [7:0] x,
                                       input logic [7:0] y, input logic [7:0] z,
                                       output logic [7:0] b0, output logic [7:0] b1,
                                       output logic [7:0] b2);
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [5:0] d;
        a  = char_value(w);
        b  = char_value(x);
        c  = char_value(y);
        d  = char_value(z);
        b0 = {a, b[5:4]};
        b1 = {b[3:0], c[5:2]};
        b2 = {c[1:0], d};
        if (y == CHAR_PAD)
        begin
            return 1;
        end
        if (z == CHAR_PAD)
        begin
            return 2;
        end
        return 3;
    endfunction

    // Advances the predicted state by one character and queues the bytes it yields.
    function automatic void predict_char(input logic [7:0] sym, input logic last);
        logic [7:0]    out_b [3];
        decoded_byte_t item;
        int            n;
        n = 0;
        if (held_count == 2'd3)
        begin
            n = expand_quad(held_chars[0], held_chars[1], held_chars[2], sym,
                            out_b[0], out_b[1], out_b[2]);
            held_count = 2'd0;
        end
        else
        begin
            held_chars[held_count] = sym;
            held_count             = held_count + 2'd1;
        end
        // A stream end flushes a partial group as if padded.
        if (last)
        begin
            if (held_count == 2'd2)
            begin
                n = expand_quad(held_chars[0], held_chars[1], CHAR_PAD, CHAR_PAD,
                                out_b[0], out_b[1], out_b[2]);
            end
            else if (held_count == 2'd3)
            begin
                n = expand_quad(held_chars[0], held_chars[1], held_chars[2], CHAR_PAD,
                                out_b[0], out_b[1], out_b[2]);
            end
            held_count = 2'd0;
            streams_ended++;
        end
        if (held_count == 2'd0)
        begin
            held_chars = '{default: 8'h00};
        end
        for (int k = 0; k < n; k++)
        begin
            bytes_emitted   = bytes_emitted + 32'd1;
            item.data       = out_b[k];
            item.run_end    = (k == n - 1);
            item.stream_end = (k == n - 1) && last;
            item.total      = bytes_emitted;
            pending_bytes.push_back(item);
        end
    endfunction

    // Character with the given index in the Base64 alphabet.
    function automatic logic [7:0] alphabet_char(input int idx);
        if (idx < 26)
        begin
            return 8'(CHAR_UPPER_A + idx);
        end
        if (idx < 52)
        begin
            return 8'(CHAR_LOWER_A + idx - 26);
        end
        if (idx < 62)
        begin
            return 8'(CHAR_DIGIT_0 + idx - 52);
        end
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Mostly alphabet characters, some padding and some arbitrary codes.
    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
        begin
            return alphabet_char($urandom_range(0, 63));
        end
        if (r < 90)
        begin
            return CHAR_PAD;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Holds push low for the given number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        push <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Offers one character and waits until the decoder takes it.
    task automatic send_char(input logic [7:0] sym, input logic last);
        @(negedge clk);
        push    <= 1'b1;
        symbol  <= sym;
        is_last <= last;
        @(posedge clk);
        while (full)
        begin
            full_cycles++;
            @(posedge clk);
        end
        predict_char(sym, last);
        chars_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            pause_sender($urandom_range(1, 18));
        end
    endtask

    task automatic send_text(input string text, input bit last_at_end);
        for (int i = 0; i < text.len(); i++)
        begin
            send_char(text[i], last_at_end && (i == text.len() - 1));
        end
    endtask

    // Sends one stream of random content; most are well formed, some are noise.
    task automatic send_random_stream();
        int         len;
        bit         clean;
        logic [7:0] ch;
        logic       last;
        clean = ($urandom_range(0, 3) != 0);
        len   = 4 * $urandom_range(0, 4) + $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            if (clean)
            begin
                ch   = ($urandom_range(0, 9) == 0) ? random_char()
                                                   : alphabet_char($urandom_range(0, 63));
                last = (i == len - 1);
                // Proper padding at the tail of a complete final group.
                if (len % 4 == 0 && i >= len - 2 && $urandom_range(0, 2) == 0)
                begin
                    ch = CHAR_PAD;
                end
            end
            else
            begin
                ch   = 8'($urandom_range(0, 255));
                last = ($urandom_range(0, 9) == 0);
            end
            send_char(ch, last);
        end
    endtask

    // Complete groups, including one with characters outside the alphabet.
    task automatic test_full_groups();
        send_text("TWFu", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h7B, 1'b1);
    endtask

    // Padding as the third and as the fourth character of a group.
    task automatic test_padding();
        send_text("QQ==", 1'b0);
        send_text("QUI=", 1'b0);
    endtask

    // Stream ends with one, two and three characters held.
    task automatic test_flush();
        send_text("A", 1'b1);
        send_text("QQ", 1'b1);
        send_text("QUJ", 1'b1);
        send_text("QU=", 1'b1);
    endtask

    // The receiver holds off while the sender keeps offering, then the sender stops and the results drain.
    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        rx_hold_req = 160;
        for (int i = 0; i < 40; i++)
        begin
            send_char(($urandom_range(0, 7) == 0) ? random_char()
                                                  : alphabet_char($urandom_range(0, 63)),
                      i == 39);
        end
        pause_sender(1);
        wait (pending_bytes.size() == 0);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_streams(input int item_goal);
        while (chars_sent < item_goal)
        begin
            send_random_stream();
        end
    endtask

    // Receiver: random stall bursts, plus long hold-offs on request.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        pop        = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compares every accepted result transaction with the oldest prediction.
    initial
    begin
        decoded_byte_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual %h (count %h)",
                             $time, data_byte, byte_count);
                    errors++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    report_field("data_byte", want.data, data_byte);
                    report_field("last_of_run", want.run_end, last_of_run);
                    report_field("end_of_stream", want.stream_end, end_of_stream);
                    report_field("byte_count", want.total, byte_count);
                    bytes_checked++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // Test sequence.
    initial
    begin
        push          = 1'b0;
        symbol        = 8'h00;
        is_last       = 1'b0;
        rst_n         = 1'b0;
        held_count    = 2'd0;
        held_chars    = '{default: 8'h00};
        bytes_emitted = 32'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_full_groups();
        test_padding();
        test_flush();
        test_backpressure();
        test_random_streams(350);

        // Final stretch runs without idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_streams(410);
        pause_sender(1);

        wait (pending_bytes.size() == 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters in %0d streams; checked %0d decoded bytes.",
                 chars_sent, streams_ended, bytes_checked);
        $display("Input was held off by a full queue for %0d cycles.", full_cycles);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
